// File: hdl/brlt_pkg.sv
// Shared types and constants for the byte-range lock table.
// Used by the interfaces, the controller, the datapath and the top level.
package brlt_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW         = $clog2(TableEntries);

  localparam int ModeW   = 2;
  localparam int KeyW    = 64;
  localparam int OwnerW  = 32;
  localparam int TimeW   = 32;
  localparam int LifeW   = 16;
  localparam int StatusW = 2;

  localparam logic [LifeW-1:0] LifetimeReset = 16'd60;

  typedef enum logic [ModeW-1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_UPDATE  = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [KeyW-1:0]   inode;
    logic [KeyW-1:0]   range_start;
    logic [KeyW-1:0]   range_end;
    logic [OwnerW-1:0] owner;
    logic [TimeW-1:0]  now;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TimeW-1:0]  expires_at;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]   inode;
    logic [KeyW-1:0]   range_start;
    logic [KeyW-1:0]   range_end;
    logic [OwnerW-1:0] owner;
    logic [TimeW-1:0]  expiry;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic            load_req;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            pass2;
    logic            commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_pass2;
    logic rsp_busy;
  } dp_status_t;

endpackage

// File: hdl/brlt_if.sv
// Valid/ready channel interfaces for lock requests and lock responses.
// Widths come from brlt_pkg.
interface brlt_req_if import brlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [KeyW-1:0]   inode;
  logic [KeyW-1:0]   range_start;
  logic [KeyW-1:0]   range_end;
  logic [OwnerW-1:0] owner;
  logic [TimeW-1:0]  now;

  modport source (output valid, mode, inode, range_start, range_end, owner, now,
                  input ready);
  modport sink   (input valid, mode, inode, range_start, range_end, owner, now,
                  output ready);
endinterface

interface brlt_rsp_if import brlt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [TimeW-1:0]   expires_at;

  modport source (output valid, status, expires_at, input ready);
  modport sink   (input valid, status, expires_at, output ready);
endinterface

// File: hdl/brlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/brlt_ctrl.sv
// Sequencer for the lock table: accepts a request, scans the table once or
// twice, then commits. Depends on brlt_pkg.
module brlt_ctrl import brlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_SCAN2  = 7'b0010000,
    S_DRAIN2 = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    req_ready_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = cnt_q;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          cnt_d          = '0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_DRAIN;
        end
      end
      // The last entry read is evaluated here; its result is registered into the
      // accumulators and seen in S_DECIDE.
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_d = '0;
        if (status_i.need_pass2) begin
          state_d = S_SCAN2;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SCAN2: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.pass2 = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_DRAIN2;
        end
      end
      S_DRAIN2: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // Wait here while the previous response word is still unclaimed.
        if (!status_i.rsp_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hdl/brlt_dpath.sv
// Lock table datapath: request registers, entry RAM, valid bits, scan
// accumulators, commit logic and the response register. Depends on brlt_pkg.
module brlt_dpath import brlt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LifeW-1:0] cfg_wdata_i,
  input  req_t             req_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o
);

  logic [LifeW-1:0]        lifetime_q;
  logic [TableEntries-1:0] valid_q;

  // Request held for the whole operation.
  logic [ModeW-1:0]  mode_q;
  logic [KeyW-1:0]   inode_q;
  logic [KeyW-1:0]   start_q;
  logic [KeyW-1:0]   end_q;
  logic [OwnerW-1:0] owner_q;
  logic [TimeW-1:0]  now_q;

  // Scan pipeline and accumulators.
  logic              eval_q;
  logic              eval_pass2_q;
  logic [IdxW-1:0]   eval_idx_q;
  logic              found_q;
  logic              k_live_q;
  logic              busy_q;
  logic              grow_busy_q;
  logic              free_found_q;
  logic [IdxW-1:0]   k_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [KeyW-1:0]   old_end_q;
  logic [KeyW-1:0]   grow_lo_q;
  logic [OwnerW-1:0] old_owner_q;

  logic              rsp_valid_q;
  rsp_t              rsp_q;

  logic [EntryW-1:0] rd_data;
  entry_t            ent;
  logic              ent_valid;
  logic              ent_live;
  logic              inode_hit;
  logic              key_hit;
  logic              ovl_req;
  logic              ovl_grow;
  logic              slot_free;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_entry;
  logic              set_valid;
  logic              clr_valid;
  status_e           cm_status;
  logic [TimeW-1:0]  cm_exp;
  logic [TimeW:0]    exp_sum;
  logic [TimeW-1:0]  expiry;

  brlt_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit && wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rd_data)
  );

  // Per-entry tests on the word that just came out of the RAM.
  always_comb begin
    ent       = entry_t'(rd_data);
    ent_valid = valid_q[eval_idx_q];
    ent_live  = ent_valid && (now_q <= ent.expiry);
    inode_hit = ent.inode == inode_q;
    key_hit   = ent_valid && inode_hit && (ent.range_start == start_q);
    ovl_req   = ent_live && inode_hit && (ent.range_start <= end_q) &&
                (start_q <= ent.range_end);
    ovl_grow  = ent_live && inode_hit && (eval_idx_q != k_q) &&
                (ent.range_start <= end_q) && (grow_lo_q <= ent.range_end);
    slot_free = !ent_valid || (now_q > ent.expiry);
  end

  // Saturating expiry of a new or refreshed lock.
  always_comb begin
    exp_sum = {1'b0, now_q} + (TimeW + 1)'(lifetime_q);
    expiry  = exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];
  end

  always_comb begin
    wr_en                = 1'b0;
    wr_addr              = k_q;
    wr_entry.inode       = inode_q;
    wr_entry.range_start = start_q;
    wr_entry.range_end   = end_q;
    wr_entry.owner       = owner_q;
    wr_entry.expiry      = expiry;
    set_valid            = 1'b0;
    clr_valid            = 1'b0;
    cm_status            = ST_DONE;
    cm_exp               = '0;
    case (mode_q)
      MODE_ACQUIRE: begin
        if ((found_q && k_live_q) || busy_q) begin
          cm_status = ST_CONFLICT;
        end else if (!found_q && !free_found_q) begin
          cm_status = ST_FULL;
        end else begin
          // An expired lock with the same key is overwritten in place.
          wr_en     = 1'b1;
          wr_addr   = found_q ? k_q : free_idx_q;
          set_valid = 1'b1;
          cm_exp    = expiry;
        end
      end
      MODE_RELEASE: begin
        if (!found_q) begin
          cm_status = ST_NOTFOUND;
        end else begin
          clr_valid = 1'b1;
        end
      end
      MODE_UPDATE: begin
        if (!found_q) begin
          cm_status = ST_NOTFOUND;
        end else if (end_q == '0) begin
          clr_valid = 1'b1;
        end else if (grow_busy_q) begin
          cm_status = ST_CONFLICT;
        end else begin
          wr_en          = 1'b1;
          wr_entry.owner = old_owner_q;
          cm_exp         = expiry;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.need_pass2 = (mode_q == MODE_UPDATE) && found_q &&
                               (end_q != '0) && (end_q > old_end_q);
  assign status_o.rsp_busy   = rsp_valid_q && !rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q   <= LifetimeReset;
      valid_q      <= '0;
      eval_q       <= 1'b0;
      eval_pass2_q <= 1'b0;
      found_q      <= 1'b0;
      busy_q       <= 1'b0;
      grow_busy_q  <= 1'b0;
      free_found_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lifetime_q <= cfg_wdata_i;
      end
      eval_q       <= cmd_i.rd_en;
      eval_pass2_q <= cmd_i.pass2;
      if (cmd_i.load_req) begin
        found_q      <= 1'b0;
        busy_q       <= 1'b0;
        grow_busy_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else if (eval_q) begin
        if (!eval_pass2_q) begin
          if (key_hit) begin
            found_q <= 1'b1;
          end
          if (ovl_req) begin
            busy_q <= 1'b1;
          end
          if (slot_free) begin
            free_found_q <= 1'b1;
          end
        end else if (ovl_grow) begin
          grow_busy_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (set_valid) begin
          valid_q[wr_addr] <= 1'b1;
        end
        if (clr_valid) begin
          valid_q[k_q] <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; only the lowest matching or free slot is kept.
  always_ff @(posedge clk_i) begin
    eval_idx_q <= cmd_i.rd_addr;
    if (cmd_i.load_req) begin
      mode_q  <= req_i.mode;
      inode_q <= req_i.inode;
      start_q <= req_i.range_start;
      end_q   <= req_i.range_end;
      owner_q <= req_i.owner;
      now_q   <= req_i.now;
    end
    if (eval_q && !eval_pass2_q && !cmd_i.load_req) begin
      if (key_hit && !found_q) begin
        k_q         <= eval_idx_q;
        k_live_q    <= ent_live;
        old_end_q   <= ent.range_end;
        grow_lo_q   <= ent.range_end + 64'd1;
        old_owner_q <= ent.owner;
      end
      if (slot_free && !free_found_q) begin
        free_idx_q <= eval_idx_q;
      end
    end
    if (cmd_i.commit) begin
      rsp_q.status     <= cm_status;
      rsp_q.expires_at <= cm_exp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: hdl/byte_range_lock_table.sv
// Byte-range lock table, top level. One request word at a time: after it is
// taken, the table is scanned one entry per cycle, and scanned a second time
// for an update that grows a lock; then the result is committed to the
// response word. The next request is taken the cycle after commit, and commit
// waits while the previous response word is still unclaimed. Reset clears all
// lock valid bits at once and sets the lifetime to 60.
module byte_range_lock_table import brlt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LifeW-1:0] cfg_wdata_i,
  brlt_req_if.sink         req_i,
  brlt_rsp_if.source       rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  req_t       req;
  rsp_t       rsp;
  logic       req_ready;
  logic       rsp_valid;

  assign req.mode        = req_i.mode;
  assign req.inode       = req_i.inode;
  assign req.range_start = req_i.range_start;
  assign req.range_end   = req_i.range_end;
  assign req.owner       = req_i.owner;
  assign req.now         = req_i.now;
  assign req_i.ready     = req_ready;

  brlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  brlt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_o.ready),
    .rsp_o      (rsp)
  );

  assign rsp_o.valid      = rsp_valid;
  assign rsp_o.status     = rsp.status;
  assign rsp_o.expires_at = rsp.expires_at;

endmodule
